FILE: src/hlbc_pkg.sv
// Package for the hashed LRU block buffer cache.
// Holds request and status codes, the sequencer state type and the tag record.
// No dependencies.
`default_nettype none

package hlbc_pkg;

    // Request codes
    localparam logic [2:0] REQ_GET     = 3'd0;
    localparam logic [2:0] REQ_MARK    = 3'd1;
    localparam logic [2:0] REQ_RELEASE = 3'd2;
    localparam logic [2:0] REQ_PIN     = 3'd3;
    localparam logic [2:0] REQ_UNPIN   = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ALLOC   = 2'd1;
    localparam logic [1:0] ST_NOFREE  = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [7:0] COUNT_MAX  = 8'd255;

    // Sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_UPD,
        S_RESP
    } t_state;

    // Tag part of one entry
    typedef struct packed {
        logic [7:0]  device;
        logic [31:0] block;
        logic        hc;
        logic [7:0]  cnt;
    } t_tag;

endpackage

`default_nettype wire

FILE: src/hashed_lru_block_buffer_cache.sv
// Top level of the hashed LRU block buffer cache: one tag memory and its sequencer.
// Depends on hlbc_pkg.
//
// Each request runs through steps set by the single read port of the entry
// memory: hashing the block number (four bits a cycle) while the addressed
// slot is read, one sweep to gather hits, free entries and bucket size, one
// read-modify-write sweep, and the response. busy is high from the accepting
// edge until the response cycle ends, and the next request can be accepted
// at the end of the following cycle, so a request is taken only once the last
// one is through. The result is shown with o_strobe for exactly one cycle and
// cannot be held off. After reset a clearing pass writes the initial buckets
// and ranks, with busy high throughout.
`default_nettype none

module hashed_lru_block_buffer_cache #(
    parameter int NUM_ENTRIES = 32,
    parameter int NUM_BUCKETS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [2:0] i_req_type,
    input  wire logic [7:0] i_device_id,
    input  wire logic [31:0] i_block_number,
    input  wire logic [4:0] i_buffer_slot,
    output logic            o_strobe,
    output logic [1:0]      o_status,
    output logic [4:0]      o_granted_slot,
    output logic            o_contents_valid
);
    import hlbc_pkg::*;

    localparam int PER  = NUM_ENTRIES / NUM_BUCKETS;
    localparam int USED = PER * NUM_BUCKETS;
    localparam int IW   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int BW   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int TW   = BW + 5;

    typedef struct packed {
        t_tag            tag;
        logic [BW-1:0]   bucket;
        logic [IW-1:0]   rank;
    } t_ent;

    // Entry memory
    t_ent mem [NUM_ENTRIES];
    t_ent          rd_data;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_ent          wr_data;

    t_state r_state, n_state;

    // Request registers
    logic [2:0]    r_req;
    logic [7:0]    r_dev;
    logic [31:0]   r_blk;
    logic [4:0]    r_slot;
    logic [BW-1:0] r_target;
    logic [2:0]    r_m;
    t_ent          r_s;

    // Sweep control
    logic [IW:0]   r_cnt;
    logic          r_rv;
    logic [IW-1:0] r_ri;
    logic [BW-1:0] r_ib;
    logic [IW-1:0] r_ir;

    // Scan results
    logic          r_hit_f, r_hf_f, r_of_f;
    logic [IW-1:0] r_hit, r_hit_rank, r_hf, r_hf_rank, r_of, r_orank;
    logic [7:0]    r_hit_cnt;
    logic          r_hit_hc;
    logic [BW-1:0] r_ob;
    logic [IW:0]   r_size;

    logic [IW+4:0] slot_w;
    logic [IW-1:0] slot_idx;
    logic          slot_ok;
    logic          sweep_done;
    logic [3:0]    nib;
    logic [TW-1:0] mod_t;
    logic [31:0]   blk_sh;
    logic [IW:0]   size_m1;

    assign slot_w   = (IW + 5)'(r_slot);
    assign slot_idx = slot_w[IW-1:0];
    assign slot_ok  = (32'(r_slot) < USED);
    assign sweep_done = (32'(r_cnt) == USED) && !r_rv;
    assign size_m1  = r_size - 1'b1;

    // Memory with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    // Read address: the slot while hashing, the sweep counter otherwise.
    always_comb begin
        if (r_state == S_MOD) begin
            rd_addr = slot_idx;
        end else begin
            rd_addr = r_cnt[IW-1:0];
        end
    end

    // Four bits of the block number per cycle into the remainder, high bits first.
    always_comb begin
        blk_sh = r_blk >> (5'd28 - {r_m, 2'b00});
        nib    = blk_sh[3:0];
        mod_t  = {r_target, nib};
        for (int k = 3; k >= 0; k--) begin
            if (mod_t >= TW'(NUM_BUCKETS << k)) begin
                mod_t = mod_t - TW'(NUM_BUCKETS << k);
            end
        end
    end

    // Write port: the clearing pass, then the update sweep.
    always_comb begin
        t_ent d;
        d       = rd_data;
        wr_en   = 1'b0;
        wr_addr = r_ri;
        wr_data = d;
        if (r_state == S_INIT) begin
            wr_en   = (32'(r_cnt) < USED);
            wr_addr = r_cnt[IW-1:0];
            wr_data = '0;
            wr_data.bucket = r_ib;
            wr_data.rank   = r_ir;
        end else if (r_state == S_UPD && r_rv) begin
            wr_en = 1'b1;
            if (r_req == REQ_GET) begin
                if (r_hit_f) begin
                    if (r_ri == r_hit && r_hit_cnt != COUNT_MAX) begin
                        wr_data.tag.cnt = d.tag.cnt + 8'd1;
                    end
                end else if (r_hf_f) begin
                    if (r_ri == r_hf) begin
                        wr_data.tag = '{device: r_dev, block: r_blk, hc: 1'b0, cnt: 8'd1};
                    end
                end else if (r_of_f) begin
                    if (r_ri == r_of) begin
                        wr_data.tag = '{device: r_dev, block: r_blk, hc: 1'b0, cnt: 8'd1};
                        wr_data.bucket = r_target;
                        wr_data.rank   = '0;
                    end else if (d.bucket == r_ob && d.rank > r_orank) begin
                        wr_data.rank = d.rank - 1'b1;
                    end else if (d.bucket == r_target) begin
                        wr_data.rank = d.rank + 1'b1;
                    end
                end
            end else if (slot_ok) begin
                case (r_req)
                    REQ_MARK: begin
                        if (r_ri == slot_idx) begin
                            wr_data.tag.hc = 1'b1;
                        end
                    end
                    REQ_PIN: begin
                        if (r_ri == slot_idx && r_s.tag.cnt != COUNT_MAX) begin
                            wr_data.tag.cnt = d.tag.cnt + 8'd1;
                        end
                    end
                    REQ_RELEASE, REQ_UNPIN: begin
                        if (r_s.tag.cnt != 8'd0) begin
                            if (r_ri == slot_idx) begin
                                wr_data.tag.cnt = d.tag.cnt - 8'd1;
                                if (r_req == REQ_RELEASE && r_s.tag.cnt == 8'd1) begin
                                    wr_data.rank = size_m1[IW-1:0];
                                end
                            end else if (r_req == REQ_RELEASE && r_s.tag.cnt == 8'd1 &&
                                         d.bucket == r_s.bucket && d.rank > r_s.rank) begin
                                wr_data.rank = d.rank - 1'b1;
                            end
                        end
                    end
                    default: begin
                        wr_data = d;
                    end
                endcase
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: if (32'(r_cnt) == USED - 1) n_state = S_IDLE;
            S_IDLE: if (start) n_state = S_MOD;
            S_MOD:  if (r_m == 3'd7) n_state = S_SCAN;
            S_SCAN: if (sweep_done) n_state = S_UPD;
            S_UPD:  if (sweep_done) n_state = S_RESP;
            S_RESP: n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        busy     = (r_state != S_IDLE);
        o_strobe = (r_state == S_RESP);
    end

    // Response fields.
    always_comb begin
        logic [31:0] g;
        g = 32'(r_slot);
        o_status = ST_OK;
        o_contents_valid = 1'b0;
        if (r_req == REQ_GET) begin
            if (r_hit_f) begin
                g = 32'(r_hit);
                o_status = (r_hit_cnt == COUNT_MAX) ? ST_RANGE : ST_OK;
                o_contents_valid = r_hit_hc;
            end else if (r_hf_f) begin
                g = 32'(r_hf);
                o_status = ST_ALLOC;
            end else if (r_of_f) begin
                g = 32'(r_of);
                o_status = ST_ALLOC;
            end else begin
                g = '0;
                o_status = ST_NOFREE;
            end
        end else if (slot_ok) begin
            o_contents_valid = r_s.tag.hc;
            case (r_req)
                REQ_MARK: o_contents_valid = 1'b1;
                REQ_PIN: begin
                    if (r_s.tag.cnt == COUNT_MAX) o_status = ST_RANGE;
                end
                REQ_RELEASE, REQ_UNPIN: begin
                    if (r_s.tag.cnt == 8'd0) o_status = ST_RANGE;
                end
                default: o_status = ST_OK;
            endcase
        end
        o_granted_slot = g[4:0];
    end

    // State and sweep control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_rv    <= 1'b0;
            r_ib    <= '0;
            r_ir    <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_INIT: begin
                    if (32'(r_ir) == PER - 1) begin
                        r_ir <= '0;
                        r_ib <= r_ib + 1'b1;
                    end else begin
                        r_ir <= r_ir + 1'b1;
                    end
                    if (n_state != S_INIT) begin
                        r_cnt <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_IDLE: r_m <= '0;
                S_MOD: begin
                    r_m   <= r_m + 1'b1;
                    r_cnt <= '0;
                    r_rv  <= 1'b0;
                end
                S_SCAN, S_UPD: begin
                    if (32'(r_cnt) < USED) begin
                        r_rv  <= 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                    if (sweep_done) r_cnt <= '0;
                end
                default: r_rv <= 1'b0;
            endcase
        end
    end

    // Request capture, hashing and scan results.
    always_ff @(posedge i_clk) begin
        r_ri <= r_cnt[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_req    <= i_req_type;
                    r_dev    <= i_device_id;
                    r_blk    <= i_block_number;
                    r_slot   <= i_buffer_slot;
                    r_target <= '0;
                end
            end
            S_MOD: begin
                r_target <= mod_t[BW-1:0];
                r_s      <= rd_data;
                r_hit_f  <= 1'b0;
                r_hf_f   <= 1'b0;
                r_of_f   <= 1'b0;
                r_size   <= '0;
            end
            S_SCAN: begin
                if (r_rv) begin
                    if (rd_data.bucket == r_s.bucket) r_size <= r_size + 1'b1;
                    if (rd_data.bucket == r_target && rd_data.tag.device == r_dev &&
                        rd_data.tag.block == r_blk &&
                        (!r_hit_f || rd_data.rank > r_hit_rank)) begin
                        r_hit_f    <= 1'b1;
                        r_hit      <= r_ri;
                        r_hit_rank <= rd_data.rank;
                        r_hit_cnt  <= rd_data.tag.cnt;
                        r_hit_hc   <= rd_data.tag.hc;
                    end
                    if (rd_data.tag.cnt == 8'd0) begin
                        if (rd_data.bucket == r_target) begin
                            if (!r_hf_f || rd_data.rank < r_hf_rank) begin
                                r_hf_f    <= 1'b1;
                                r_hf      <= r_ri;
                                r_hf_rank <= rd_data.rank;
                            end
                        end else if (!r_of_f || rd_data.bucket < r_ob ||
                                     (rd_data.bucket == r_ob && rd_data.rank < r_orank)) begin
                            r_of_f  <= 1'b1;
                            r_of    <= r_ri;
                            r_ob    <= rd_data.bucket;
                            r_orank <= rd_data.rank;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the hashed LRU block buffer cache.
// Predicts every response from its own copy of the tag store and checks it field by field.
// Depends on hlbc_pkg and hashed_lru_block_buffer_cache.
`default_nettype none

module tb;
    import hlbc_pkg::*;

    localparam int ENTRIES   = 32;
    localparam int BUCKETS   = 8;
    localparam int PER_BKT   = ENTRIES / BUCKETS;
    localparam int USED      = PER_BKT * BUCKETS;
    localparam int IDLE_LIMIT = 20000;
    localparam int NO_BUCKET = 255;

    typedef struct {
        logic [1:0] status;
        logic [4:0] slot;
        logic       cv;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = '0;
    logic [7:0]  i_device_id = '0;
    logic [31:0] i_block_number = '0;
    logic [4:0]  i_buffer_slot = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [4:0]  o_granted_slot;
    logic        o_contents_valid;

    // Shadow copy of the tag store
    logic [7:0]  sh_dev [ENTRIES];
    logic [31:0] sh_blk [ENTRIES];
    logic        sh_hc [ENTRIES];
    int          sh_cnt [ENTRIES];
    int          sh_bkt [ENTRIES];
    int          sh_rank [ENTRIES];

    t_resp pending_resp[$];
    int    errors = 0;
    int    quiet_cycles = 0;
    int    send_idle_pct = 0;

    hashed_lru_block_buffer_cache #(
        .NUM_ENTRIES(ENTRIES),
        .NUM_BUCKETS(BUCKETS)
    ) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_device_id(i_device_id),
        .i_block_number(i_block_number), .i_buffer_slot(i_buffer_slot),
        .o_strobe(o_strobe), .o_status(o_status),
        .o_granted_slot(o_granted_slot), .o_contents_valid(o_contents_valid)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void store_reset();
        for (int i = 0; i < ENTRIES; i++) begin
            sh_dev[i] = '0;
            sh_blk[i] = '0;
            sh_hc[i] = 1'b0;
            sh_cnt[i] = 0;
            sh_bkt[i] = (i < USED) ? i / PER_BKT : NO_BUCKET;
            sh_rank[i] = (i < USED) ? i % PER_BKT : 0;
        end
    endfunction

    // Least recent free entry of a bucket, or -1.
    function automatic int oldest_free(int bkt);
        int best;
        best = -1;
        for (int i = 0; i < USED; i++)
            if (sh_bkt[i] == bkt && sh_cnt[i] == 0 &&
                (best < 0 || sh_rank[i] < sh_rank[best]))
                best = i;
        return best;
    endfunction

    // Ranks above the departing entry move down by one.
    function automatic void close_gap(int e);
        for (int i = 0; i < USED; i++)
            if (i != e && sh_bkt[i] == sh_bkt[e] && sh_rank[i] > sh_rank[e])
                sh_rank[i]--;
    endfunction

    // Applies one request to the shadow store and returns the expected response.
    function automatic t_resp cache_predict(logic [2:0] req, logic [7:0] dev,
                                            logic [31:0] blk, logic [4:0] slot);
        t_resp r;
        int home, hit, f, n;
        r.status = ST_OK;
        r.slot = slot;
        r.cv = 1'b0;
        if (req == REQ_GET) begin
            home = int'(blk % BUCKETS);
            hit = -1;
            for (int i = 0; i < USED; i++)
                if (sh_bkt[i] == home && sh_dev[i] == dev && sh_blk[i] == blk &&
                    (hit < 0 || sh_rank[i] > sh_rank[hit]))
                    hit = i;
            if (hit >= 0) begin
                if (sh_cnt[hit] >= 255) r.status = ST_RANGE;
                else sh_cnt[hit]++;
                r.slot = hit[4:0];
                r.cv = sh_hc[hit];
            end else begin
                f = oldest_free(home);
                for (int b = 0; b < BUCKETS && f < 0; b++) begin
                    if (b == home) continue;
                    f = oldest_free(b);
                    if (f >= 0) begin
                        close_gap(f);
                        for (int i = 0; i < USED; i++)
                            if (sh_bkt[i] == home) sh_rank[i]++;
                        sh_bkt[f] = home;
                        sh_rank[f] = 0;
                    end
                end
                if (f >= 0) begin
                    sh_dev[f] = dev;
                    sh_blk[f] = blk;
                    sh_hc[f] = 1'b0;
                    sh_cnt[f] = 1;
                    r.status = ST_ALLOC;
                    r.slot = f[4:0];
                end else begin
                    r.status = ST_NOFREE;
                    r.slot = '0;
                end
            end
        end else if (slot < USED) begin
            if (req == REQ_MARK) begin
                sh_hc[slot] = 1'b1;
            end else if (req == REQ_RELEASE || req == REQ_UNPIN) begin
                if (sh_cnt[slot] == 0) begin
                    r.status = ST_RANGE;
                end else begin
                    sh_cnt[slot]--;
                    if (req == REQ_RELEASE && sh_cnt[slot] == 0) begin
                        close_gap(slot);
                        n = 0;
                        for (int i = 0; i < USED; i++)
                            if (sh_bkt[i] == sh_bkt[slot]) n++;
                        sh_rank[slot] = n - 1;
                    end
                end
            end else if (req == REQ_PIN) begin
                if (sh_cnt[slot] >= 255) r.status = ST_RANGE;
                else sh_cnt[slot]++;
            end
            r.cv = sh_hc[slot];
        end
        return r;
    endfunction

    // Response checker and watchdog
    always @(posedge i_clk) begin
        t_resp e;
        if (o_strobe) begin
            quiet_cycles <= 0;
            if (pending_resp.size() == 0) begin
                $error("response with no request outstanding");
                errors++;
            end else begin
                e = pending_resp.pop_front();
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_granted_slot !== e.slot) begin
                    $error("granted_slot expected %0d actual %0d", e.slot, o_granted_slot);
                    errors++;
                end
                if (o_contents_valid !== e.cv) begin
                    $error("contents_valid expected %0d actual %0d", e.cv,
                           o_contents_valid);
                    errors++;
                end
            end
        end else if (start && !busy && i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Sends one request: random gap first, then held until accepted.
    task automatic send_request(logic [2:0] req, logic [7:0] dev, logic [31:0] blk,
                                logic [4:0] slot);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_req_type <= req;
        i_device_id <= dev;
        i_block_number <= blk;
        i_buffer_slot <= slot;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_resp.push_back(cache_predict(req, dev, blk, slot));
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_resp.size() != 0) @(negedge i_clk);
    endtask

    // Extremes, every request code, overflow, underflow, stealing
    task automatic test_directed();
        send_request(REQ_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_request(REQ_GET, 8'h00, 32'h0000_0000, 5'd0);
        send_request(REQ_GET, 8'h00, 32'h0000_0000, 5'd0);
        send_request(REQ_MARK, 8'h00, 32'h0, 5'd0);
        send_request(REQ_GET, 8'h00, 32'h0000_0000, 5'd0);
        send_request(REQ_RELEASE, 8'h00, 32'h0, 5'd1);
        send_request(REQ_UNPIN, 8'h00, 32'h0, 5'd2);
        send_request(REQ_PIN, 8'h00, 32'h0, 5'd3);
        send_request(REQ_UNPIN, 8'h00, 32'h0, 5'd3);
        send_request(3'd5, 8'hA5, 32'h5A5A_5A5A, 5'd0);
        send_request(3'd7, 8'h00, 32'h0, 5'd31);
        // Pin one entry up to its ceiling, then once more.
        for (int k = 0; k < 256; k++) send_request(REQ_PIN, 8'h00, 32'h0, 5'd5);
        send_request(REQ_GET, 8'h00, 32'h0, 5'd0);
        // Fill bucket 3 and beyond, forcing steals from other buckets.
        for (int k = 0; k < 12; k++)
            send_request(REQ_GET, 8'h11, 32'd3 + 32'd8 * k, 5'd0);
        for (int k = 0; k < 8; k++) send_request(REQ_RELEASE, 8'h00, 32'h0, 5'(k));
        wait_drained();
    endtask

    // Mostly well-formed get/use/release sequences on a small block set
    task automatic test_random(int count);
        logic [2:0]  req;
        logic [31:0] blk;
        logic [4:0]  slot;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: req = REQ_GET;
                4:          req = REQ_MARK;
                5, 6, 7:    req = REQ_RELEASE;
                8:          req = ($urandom_range(1) != 0) ? REQ_PIN : REQ_UNPIN;
                default:    req = 3'($urandom_range(7));
            endcase
            blk = ($urandom_range(7) == 0) ? $urandom() : 32'($urandom_range(47));
            slot = ($urandom_range(3) == 0) ? 5'($urandom()) :
                   (pending_resp.size() == 0 ? 5'($urandom_range(USED - 1)) :
                    pending_resp[$].slot);
            send_request(req, 8'($urandom_range(3) == 0 ? $urandom() : 1), blk, slot);
        end
    endtask

    initial begin
        store_reset();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 19;
        test_directed();
        test_random(170);
        // Sender holds off until every outstanding response is back.
        wait_drained();
        send_idle_pct = 51;
        test_random(170);
        send_idle_pct = 0;
        test_random(170);
        wait_drained();
        repeat (100) @(negedge i_clk);
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire

FILE: filelist.f
src/hlbc_pkg.sv
src/hashed_lru_block_buffer_cache.sv
tb/sv/tb.sv
